>>> hw/rtl/tfb_pkg.sv
// Package: shared types, codes and helper functions for the text framebuffer.
`default_nettype none
package tfb_pkg;
    localparam int STORE_BYTES_DEF   = 504;
    localparam int PANEL_COLUMNS_DEF = 84;
    localparam int GLYPH_COUNT_DEF   = 160;

    localparam logic [2:0] OP_LOAD  = 3'd0;
    localparam logic [2:0] OP_SETC  = 3'd1;
    localparam logic [2:0] OP_DRAW  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_PULL  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_WRAP = 2'd1;
    localparam logic [1:0] ST_OOB  = 2'd2;

    localparam logic [7:0] MISSING_ROW = 8'd95;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic       double_size;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic [7:0] glyph_index;
        logic [2:0] glyph_column;
        logic [7:0] glyph_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] lcd_byte;
        logic       data_not_command;
        logic       last;
        logic       refresh_pending;
    } out_item_t;

    // Double each bit of a nibble into two adjacent bits.
    function automatic logic [7:0] widen_nibble(input logic [3:0] n);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            r[2*k]   = n[k];
            r[2*k+1] = n[k];
        end
        return r;
    endfunction

    // Map a character code to its glyph row.
    function automatic logic [7:0] glyph_row(input logic [7:0] code);
        logic [7:0] r;
        if (code >= 8'h20 && code <= 8'h7F)
            r = code - 8'd32;
        else if (code >= 8'hC0)
            r = code - 8'd96;
        else
            r = MISSING_ROW;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/tfb_if.sv
// Interface: valid/ready channel carrying one item.
`default_nettype none
interface tfb_if #(parameter type item_t = logic) ();
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/text_framebuffer_with_dirty_window.sv
// Top level: text framebuffer with a dirty window and a refresh byte stream.
// One item in, one result out. A glyph load or cursor set is answered from the
// idle state through the output state; a refresh data byte adds one display
// memory read. For a refresh column or bank command the bank and column of the
// low mark are found by repeated subtraction of the panel width. A character
// is written through the single-port display memory: each glyph column is first
// read from the font memory, then written as one byte (four for double size),
// and the gap byte follows. A clear walks the whole display memory. After reset
// the block runs the same walk to zero the display memory and accepts no item
// meanwhile. Results sit in an output register; the next item is taken the
// cycle after the result has been taken.
`default_nettype none
module text_framebuffer_with_dirty_window
    import tfb_pkg::*;
#(
    parameter int STORE_BYTES   = STORE_BYTES_DEF,
    parameter int PANEL_COLUMNS = PANEL_COLUMNS_DEF,
    parameter int GLYPH_COUNT   = GLYPH_COUNT_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    tfb_if.sink      in_ch,
    tfb_if.source    out_ch
);
    localparam int AW  = $clog2(STORE_BYTES + PANEL_COLUMNS + 16);
    localparam int SAW = $clog2(STORE_BYTES);
    localparam int FD  = GLYPH_COUNT * 5;
    localparam int FAW = $clog2(FD);
    localparam logic [AW-1:0] LAST_A = AW'(STORE_BYTES - 1);
    localparam logic [AW-1:0] NB     = AW'(STORE_BYTES);
    localparam logic [AW-1:0] PC     = AW'(PANEL_COLUMNS);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FRD   = 4'd2;
    localparam logic [3:0] S_FWAIT = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_GAP   = 4'd5;
    localparam logic [3:0] S_DRD   = 4'd6;
    localparam logic [3:0] S_DWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BANK = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] low_reg, low_next;
    logic [AW-1:0] high_reg, high_next;
    logic          pend_reg, pend_next;
    logic [1:0]    phase_reg, phase_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]    col_reg, col_next;
    logic [1:0]    sub_reg, sub_next;
    logic [FAW-1:0] base_reg, base_next;
    logic          dbl_reg, dbl_next;
    logic [7:0]    glyph_reg, glyph_next;
    logic          clr_op_reg, clr_op_next;
    logic [AW-1:0] div_rem_reg, div_rem_next;
    logic [AW-1:0] div_q_reg, div_q_next;
    out_item_t     res_reg, res_next;
    logic          ovalid_reg, ovalid_next;

    logic          fwe;
    logic [FAW-1:0] fwaddr, fraddr;
    logic [7:0]    frdata;
    logic          dwe;
    logic [AW-1:0] daddr_w;
    logic [7:0]    dwdata, drdata;

    in_item_t it;
    assign it = in_ch.data;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = res_reg;

    tfb_font_mem #(.DEPTH(FD)) u_font (
        .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(it.glyph_byte),
        .raddr(fraddr), .rdata(frdata)
    );
    tfb_disp_mem #(.DEPTH(STORE_BYTES)) u_disp (
        .clk(clk), .we(dwe), .addr(daddr_w[SAW-1:0]), .wdata(dwdata),
        .rdata(drdata)
    );

    // Glyph load write and cursor math.
    logic [15:0] setpos;
    logic [7:0]  row;
    always_comb
    begin
        fwe    = acc && it.operation == OP_LOAD &&
                 16'(it.glyph_index) < 16'(GLYPH_COUNT) && it.glyph_column < 3'd5;
        fwaddr = FAW'(16'(it.glyph_index) * 16'd5 + 16'(it.glyph_column));
        fraddr = base_reg + FAW'(col_reg);
        setpos = 16'(it.cell_x) * 16'd6 + 16'(it.cell_y) * 16'(PANEL_COLUMNS);
        row    = glyph_row(it.char_code);
        if (16'(row) >= 16'(GLYPH_COUNT))
            row = MISSING_ROW;
    end

    // Write address for the current column step.
    logic [AW-1:0] wpos, gpos, gsum;
    logic [7:0]    wbyte;
    always_comb
    begin
        if (!dbl_reg)
        begin
            wpos  = cursor_reg + AW'(col_reg);
            wbyte = glyph_reg;
        end
        else
        begin
            wpos  = cursor_reg + AW'({col_reg, 1'b0}) + AW'(sub_reg[0])
                    + (sub_reg[1] ? PC : '0);
            wbyte = sub_reg[1] ? widen_nibble(glyph_reg[7:4])
                               : widen_nibble(glyph_reg[3:0]);
        end
        gsum = cursor_reg + AW'(11);
        if (!dbl_reg)
            gpos = cursor_reg + AW'(5);
        else
            gpos = (gsum >= NB) ? gsum - NB : gsum;
    end

    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        pend_next    = pend_reg;
        phase_next   = phase_reg;
        ptr_next     = ptr_reg;
        clr_next     = clr_reg;
        col_next     = col_reg;
        sub_next     = sub_reg;
        base_next    = base_reg;
        dbl_next     = dbl_reg;
        glyph_next   = glyph_reg;
        clr_op_next  = clr_op_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        res_next     = res_reg;
        ovalid_next  = ovalid_reg;
        dwe          = 1'b0;
        daddr_w      = ptr_reg;
        dwdata       = '0;
        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                // Zero one byte per cycle.
                dwe     = 1'b1;
                daddr_w = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_A)
                begin
                    clr_next = '0;
                    if (clr_op_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    res_next = '0;
                    state_next = S_OUT;
                    unique case (it.operation)
                        OP_SETC:
                        begin
                            if (it.cell_x > 8'd13 || it.cell_y > 8'd5 ||
                                setpos >= 16'(STORE_BYTES))
                                res_next.status = ST_OOB;
                            else
                                cursor_next = AW'(setpos);
                        end
                        OP_DRAW:
                        begin
                            if (cursor_reg < low_reg)
                                low_next = cursor_reg;
                            base_next  = FAW'(16'(row) * 16'd5);
                            dbl_next   = it.double_size;
                            col_next   = '0;
                            sub_next   = '0;
                            state_next = S_FRD;
                        end
                        OP_CLEAR:
                        begin
                            low_next    = '0;
                            high_next   = LAST_A;
                            pend_next   = 1'b1;
                            clr_next    = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_CLR;
                        end
                        OP_PULL:
                        begin
                            if (phase_reg == PH_DATA)
                                state_next = S_DRD;
                            else
                            begin
                                // Split the low mark into bank and column.
                                div_rem_next = low_reg;
                                div_q_next   = '0;
                                state_next   = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_rem_reg >= PC)
                begin
                    div_rem_next = div_rem_reg - PC;
                    div_q_next   = div_q_reg + AW'(1);
                end
                else
                begin
                    if (phase_reg == PH_BANK)
                    begin
                        res_next.lcd_byte = 8'h40 | 8'(div_q_reg);
                        if (low_reg > high_reg)
                        begin
                            res_next.last = 1'b1;
                            low_next = LAST_A; high_next = '0;
                            pend_next = 1'b0; phase_next = PH_IDLE;
                        end
                        else
                        begin
                            ptr_next = low_reg;
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        res_next.lcd_byte = 8'h80 | 8'(div_rem_reg);
                        phase_next = PH_BANK;
                    end
                    state_next = S_OUT;
                end
            end
            S_FRD:
                state_next = S_FWAIT;
            S_FWAIT:
            begin
                glyph_next = frdata;
                state_next = S_WR;
            end
            S_WR:
            begin
                // Drop writes past the end of the store.
                dwe     = wpos < NB;
                daddr_w = wpos;
                dwdata  = wbyte;
                if (dbl_reg && sub_reg != 2'd3)
                    sub_next = sub_reg + 2'd1;
                else
                begin
                    sub_next = '0;
                    col_next = col_reg + 3'd1;
                    state_next = (col_reg == 3'd4) ? S_GAP : S_FRD;
                end
            end
            S_GAP:
            begin
                dwe     = gpos < NB;
                daddr_w = gpos;
                if (gpos > high_reg)
                    high_next = (gpos > LAST_A) ? LAST_A : gpos;
                if (gpos >= LAST_A)
                begin
                    cursor_next = '0;
                    res_next.status = ST_WRAP;
                end
                else
                    cursor_next = gpos + AW'(1);
                state_next = S_OUT;
            end
            S_DRD:
            begin
                daddr_w = ptr_reg;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                res_next.data_not_command = 1'b1;
                res_next.lcd_byte = (ptr_reg < NB) ? drdata : 8'h00;
                if (ptr_reg >= high_reg)
                begin
                    res_next.last = 1'b1;
                    low_next = LAST_A; high_next = '0;
                    pend_next = 1'b0; phase_next = PH_IDLE;
                end
                else
                    ptr_next = ptr_reg + AW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                res_next.refresh_pending = pend_next;
                clr_op_next = 1'b0;
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cursor_reg <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            pend_reg   <= 1'b0;
            phase_reg  <= PH_IDLE;
            ptr_reg    <= '0;
            clr_reg    <= '0;
            clr_op_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            pend_reg   <= pend_next;
            phase_reg  <= phase_next;
            ptr_reg    <= ptr_next;
            clr_reg    <= clr_next;
            clr_op_reg <= clr_op_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        sub_reg     <= sub_next;
        base_reg    <= base_next;
        dbl_reg     <= dbl_next;
        glyph_reg   <= glyph_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        res_reg     <= res_next;
    end

    a_cursor_in: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg < NB) else $error("cursor outside store");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(res_reg))
        else $error("result dropped");
endmodule
`default_nettype wire

>>> hw/rtl/tfb_font_mem.sv
// Font memory: synchronous glyph store, one write and one read port.
`default_nettype none
module tfb_font_mem
    import tfb_pkg::*;
#(
    parameter int DEPTH = GLYPH_COUNT_DEF * 5,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/tfb_disp_mem.sv
// Display memory: synchronous single-port byte store.
`default_nettype none
module tfb_disp_mem
    import tfb_pkg::*;
#(
    parameter int DEPTH = STORE_BYTES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic [7:0]         rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else
            rdata <= mem[addr];
    end
endmodule
`default_nettype wire
